// ===== hw/rtl/wfdr_pkg.sv =====
// wfdr_pkg: shared types, constants and the arctangent table of the waypoint follower
// used by waypoint_follower_dead_reckoning; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package wfdr_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(CORDIC_STEPS);

    // cordic vector width, angle accumulator width, wrap register width
    localparam int CW = 36;
    localparam int ZW = 27;
    localparam int MW = 29;

    typedef logic signed [MW-1:0] t_ang;

    localparam t_ang DEG90  = 29'sd5898240;
    localparam t_ang DEG180 = 29'sd11796480;
    localparam t_ang DEG360 = 29'sd23592960;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic [9:0]           PWM_MAX     = 10'd1023;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_PUSH   = 3'd1;
    localparam logic [2:0] OP_POSE   = 3'd2;
    localparam logic [2:0] OP_HALT   = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;

    localparam logic [2:0] CFG_TURN_THR   = 3'd0;
    localparam logic [2:0] CFG_RADIUS     = 3'd1;
    localparam logic [2:0] CFG_TURN_STEP  = 3'd2;
    localparam logic [2:0] CFG_DRIVE_STEP = 3'd3;
    localparam logic [2:0] CFG_DUTY       = 3'd4;

    typedef struct packed {
        logic       l1;
        logic       l2;
        logic [9:0] lpwm;
        logic       r1;
        logic       r2;
        logic [9:0] rpwm;
    } t_motor;

    function automatic logic [23:0] arc(input logic [4:0] k);
        logic [23:0] v;
        unique case (k)
            5'd0:  v = 24'd2949120;
            5'd1:  v = 24'd1740967;
            5'd2:  v = 24'd919879;
            5'd3:  v = 24'd466945;
            5'd4:  v = 24'd234379;
            5'd5:  v = 24'd117304;
            5'd6:  v = 24'd58666;
            5'd7:  v = 24'd29335;
            5'd8:  v = 24'd14668;
            5'd9:  v = 24'd7334;
            5'd10: v = 24'd3667;
            5'd11: v = 24'd1833;
            5'd12: v = 24'd917;
            5'd13: v = 24'd458;
            5'd14: v = 24'd229;
            5'd15: v = 24'd115;
            5'd16: v = 24'd57;
            5'd17: v = 24'd29;
            5'd18: v = 24'd14;
            5'd19: v = 24'd7;
            5'd20: v = 24'd4;
            5'd21: v = 24'd2;
            5'd22: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/waypoint_follower_dead_reckoning.sv =====
// waypoint_follower_dead_reckoning: waypoint queue, arrival test, cordic bearing and
// sin/cos dead reckoning on one shared cordic stage and one shared multiplier
// depends on wfdr_pkg
//
// usage: one input transfer (operation, coordinates, heading) gives exactly one result
// transfer (motor pins and duty, pose, queue level, dropped flag). the input channel
// stalls from the accepted transfer until the result is in the output register; the
// next item is taken while that result still waits for the receiver.
// push, set pose, halt, resume and unknown codes go from idle straight to the finish state,
// which loads the output register. a tick that ends early (empty queue or halted) passes
// the arrival test states and the check state before finishing. a steering tick iterates
// the cordic stage once per step (CORDIC_STEPS = 16) for the bearing, skipped when the
// waypoint lies on the pose, and again for sin/cos when it drives straight; the multiplier
// runs 3 times for the arrival test when the waypoint is inside the radius box and twice
// for the position update, and add/subtract steps per wrap bring the angles into range.
// reset clears the queue, pose, halt flag and motor drive and loads the register
// defaults; the waypoint memory needs no clearing.
// while the receiver stalls the output register holds; a finished item waits in
// its last state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module waypoint_follower_dead_reckoning (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [30:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [25:0] i_heading_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_left_in1,
    output logic                    o_left_in2,
    output logic [9:0]              o_left_pwm,
    output logic                    o_right_in1,
    output logic                    o_right_in2,
    output logic [9:0]              o_right_pwm,
    output logic signed [31:0]      o_pose_x_out,
    output logic signed [31:0]      o_pose_y_out,
    output logic signed [25:0]      o_heading_out,
    output logic [6:0]              o_queue_level,
    output logic                    o_push_dropped
);

    localparam int CW = wfdr_pkg::CW;
    localparam int ZW = wfdr_pkg::ZW;
    localparam int MW = wfdr_pkg::MW;
    localparam int QW = wfdr_pkg::QW;
    localparam int FW = wfdr_pkg::FW;
    localparam int SW = wfdr_pkg::SW;

    typedef enum logic [18:0] {
        S_IDLE     = 19'b0000000000000000001,
        S_ARR_RD   = 19'b0000000000000000010,
        S_ARR_CMP  = 19'b0000000000000000100,
        S_SQ_X     = 19'b0000000000000001000,
        S_SQ_Y     = 19'b0000000000000010000,
        S_SQ_R     = 19'b0000000000000100000,
        S_CHK      = 19'b0000000000001000000,
        S_BR_RD    = 19'b0000000000010000000,
        S_BR_PRE   = 19'b0000000000100000000,
        S_CORD     = 19'b0000000001000000000,
        S_ERR_INIT = 19'b0000000010000000000,
        S_ERR_WRAP = 19'b0000000100000000000,
        S_DECIDE   = 19'b0000001000000000000,
        S_TURN_MOD = 19'b0000010000000000000,
        S_SC_WRAP  = 19'b0000100000000000000,
        S_MUL_S    = 19'b0001000000000000000,
        S_ADD_S    = 19'b0010000000000000000,
        S_ADD_C    = 19'b0100000000000000000,
        S_FINISH   = 19'b1000000000000000000
    } t_state;

    t_state r_state;

    logic [23:0] r_turn_thr;
    logic [30:0] r_radius;
    logic [23:0] r_turn_step;
    logic [23:0] r_drive_step;
    logic [9:0]  r_duty;

    logic [63:0] r_mem [wfdr_pkg::QUEUE_DEPTH];
    logic [63:0] r_rd;
    logic [QW-1:0] r_head;
    logic [QW-1:0] r_tail;
    logic [FW-1:0] r_fill;

    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [25:0] r_hd;
    logic               r_halted;
    wfdr_pkg::t_motor   r_motor;
    logic               r_dropped;

    logic [30:0]          r_ax;
    logic [30:0]          r_ay;
    logic signed [CW-1:0] r_a;
    logic signed [CW-1:0] r_b;
    logic signed [ZW-1:0] r_z;
    logic                 r_vec;
    logic [SW-1:0]        r_i;
    wfdr_pkg::t_ang       r_m;
    wfdr_pkg::t_ang       r_err;
    logic signed [65:0]   r_prod;

    logic                    r_out_valid;
    wfdr_pkg::t_motor        r_o_motor;
    logic signed [31:0]      r_o_px;
    logic signed [31:0]      r_o_py;
    logic signed [25:0]      r_o_hd;
    logic [FW-1:0]           r_o_lvl;
    logic                    r_o_drop;

    logic in_xfer;
    logic wr_en;
    logic [QW-1:0] head_inc;
    logic [QW-1:0] tail_inc;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;

    logic signed [32:0] m_a;
    logic signed [32:0] m_b;
    logic signed [65:0] m_p;

    logic signed [CW-1:0] sh_a;
    logic signed [CW-1:0] sh_b;
    logic                 pos;
    logic signed [ZW-1:0] arc_z;

    wfdr_pkg::t_ang m_sub;
    wfdr_pkg::t_ang m_add;
    wfdr_pkg::t_ang m_c;
    wfdr_pkg::t_ang abs_err;
    wfdr_pkg::t_ang hd_ext;

    logic signed [65:0] inc_full;
    logic signed [33:0] sum_x;
    logic signed [33:0] sum_y;
    logic [9:0]         duty_sat;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33] != v[32] || v[32] != v[31]) begin
            r = v[33] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic wfdr_pkg::t_motor motor_set(input logic [9:0] d, input logic l1,
                                                   input logic l2, input logic r1,
                                                   input logic r2);
        wfdr_pkg::t_motor v;
        if (d == 10'd0) begin
            v = '{l1: 1'b1, l2: 1'b1, lpwm: 10'd0, r1: 1'b1, r2: 1'b1, rpwm: 10'd0};
        end else begin
            v = '{l1: l1, l2: l2, lpwm: d, r1: r1, r2: r2, rpwm: d};
        end
        return v;
    endfunction

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign wr_en    = in_xfer && i_operation == wfdr_pkg::OP_PUSH
                      && r_fill < FW'(wfdr_pkg::QUEUE_DEPTH);
    assign head_inc = (r_head == QW'(wfdr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == QW'(wfdr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    assign dx = {r_rd[63], r_rd[63:32]} - {r_px[31], r_px};
    assign dy = {r_rd[31], r_rd[31:0]} - {r_py[31], r_py};
    assign ax = dx[32] ? 33'(-dx) : 33'(dx);
    assign ay = dy[32] ? 33'(-dy) : 33'(dy);
    assign ex = {{(CW - 33){dx[32]}}, dx};
    assign ey = {{(CW - 33){dy[32]}}, dy};

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_SQ_X: begin
                m_a = {2'b00, r_ax};
                m_b = {2'b00, r_ax};
            end
            S_SQ_Y: begin
                m_a = {2'b00, r_ay};
                m_b = {2'b00, r_ay};
            end
            S_SQ_R: begin
                m_a = {2'b00, r_radius};
                m_b = {2'b00, r_radius};
            end
            S_MUL_S: begin
                m_a = {9'd0, r_drive_step};
                m_b = {r_b[31], r_b[31:0]};
            end
            S_ADD_S: begin
                m_a = {9'd0, r_drive_step};
                m_b = {r_a[31], r_a[31:0]};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign m_p = m_a * m_b;

    // shared cordic stage
    assign sh_a  = r_a >>> r_i;
    assign sh_b  = r_b >>> r_i;
    assign pos   = r_vec ? r_b[CW-1] : !r_z[ZW-1];
    assign arc_z = ZW'(wfdr_pkg::arc(5'(r_i)));

    assign m_sub   = r_m - wfdr_pkg::DEG360;
    assign m_add   = r_m + wfdr_pkg::DEG360;
    assign m_c     = r_m - wfdr_pkg::DEG180;
    assign abs_err = r_err[MW-1] ? -r_err : r_err;
    assign hd_ext  = {{(MW - 26){r_hd[25]}}, r_hd};

    assign inc_full = (r_prod + 66'sd536870912) >>> 30;
    assign sum_x    = {{2{r_px[31]}}, r_px} + inc_full[33:0];
    assign sum_y    = {{2{r_py[31]}}, r_py} + inc_full[33:0];
    assign duty_sat = (r_duty > wfdr_pkg::PWM_MAX) ? wfdr_pkg::PWM_MAX : r_duty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= {i_coord_x, i_coord_y};
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_turn_thr   <= 24'd655360;
            r_radius     <= 31'd655360;
            r_turn_step  <= 24'd521966;
            r_drive_step <= 24'd3360842;
            r_duty       <= 10'd511;
            r_head       <= '0;
            r_tail       <= '0;
            r_fill       <= '0;
            r_px         <= '0;
            r_py         <= '0;
            r_hd         <= '0;
            r_halted     <= 1'b0;
            r_motor      <= '0;
            r_dropped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wfdr_pkg::CFG_TURN_THR:   r_turn_thr   <= i_cfg_data[23:0];
                    wfdr_pkg::CFG_RADIUS:     r_radius     <= i_cfg_data;
                    wfdr_pkg::CFG_TURN_STEP:  r_turn_step  <= i_cfg_data[23:0];
                    wfdr_pkg::CFG_DRIVE_STEP: r_drive_step <= i_cfg_data[23:0];
                    wfdr_pkg::CFG_DUTY:       r_duty       <= i_cfg_data[9:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_dropped <= (i_operation == wfdr_pkg::OP_PUSH) && !wr_en;
                        r_state   <= (i_operation == wfdr_pkg::OP_TICK) ? S_ARR_RD
                                                                         : S_FINISH;
                        unique case (i_operation)
                            wfdr_pkg::OP_TICK: ;
                            wfdr_pkg::OP_PUSH: begin
                                if (wr_en) begin
                                    r_tail <= tail_inc;
                                    r_fill <= r_fill + 1'b1;
                                end
                            end
                            wfdr_pkg::OP_POSE: begin
                                r_px <= i_coord_x;
                                r_py <= i_coord_y;
                                r_hd <= i_heading_in;
                            end
                            wfdr_pkg::OP_HALT: begin
                                r_halted <= 1'b1;
                                r_motor  <= motor_set(10'd0, 1'b1, 1'b1, 1'b1, 1'b1);
                            end
                            wfdr_pkg::OP_RESUME: r_halted <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                S_ARR_RD: begin
                    r_state <= (r_fill == '0) ? S_CHK : S_ARR_CMP;
                end
                S_ARR_CMP: begin
                    r_ax <= ax[30:0];
                    r_ay <= ay[30:0];
                    if (ax <= {2'b00, r_radius} && ay <= {2'b00, r_radius}) begin
                        r_state <= S_SQ_X;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_SQ_X: begin
                    r_prod  <= m_p;
                    r_state <= S_SQ_Y;
                end
                S_SQ_Y: begin
                    r_prod  <= r_prod + m_p;
                    r_state <= S_SQ_R;
                end
                S_SQ_R: begin
                    if (r_prod <= m_p) begin
                        r_head <= head_inc;
                        r_fill <= r_fill - 1'b1;
                    end
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= (r_fill == '0 || r_halted) ? S_FINISH : S_BR_RD;
                end
                S_BR_RD: begin
                    r_state <= S_BR_PRE;
                end
                S_BR_PRE: begin
                    r_vec <= 1'b1;
                    r_i   <= '0;
                    priority if (dx == '0 && dy == '0) begin
                        r_z     <= '0;
                        r_state <= S_ERR_INIT;
                    end else if (dy[32] && !dx[32]) begin
                        r_a     <= ex;
                        r_b     <= -ey;
                        r_z     <= ZW'(wfdr_pkg::DEG90);
                        r_state <= S_CORD;
                    end else if (dy[32]) begin
                        r_a     <= -ex;
                        r_b     <= ey;
                        r_z     <= -ZW'(wfdr_pkg::DEG90);
                        r_state <= S_CORD;
                    end else begin
                        r_a     <= ey;
                        r_b     <= ex;
                        r_z     <= '0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (pos) begin
                        r_a <= r_a - sh_b;
                        r_b <= r_b + sh_a;
                        r_z <= r_z - arc_z;
                    end else begin
                        r_a <= r_a + sh_b;
                        r_b <= r_b - sh_a;
                        r_z <= r_z + arc_z;
                    end
                    if (r_i == SW'(wfdr_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= r_vec ? S_ERR_INIT : S_MUL_S;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_ERR_INIT: begin
                    r_m <= {{(MW - ZW){r_z[ZW-1]}}, r_z} - hd_ext + wfdr_pkg::DEG180;
                    r_state <= S_ERR_WRAP;
                end
                S_ERR_WRAP: begin
                    priority if (r_m >= wfdr_pkg::DEG360) begin
                        r_m <= m_sub;
                    end else if (r_m < 0) begin
                        r_m <= m_add;
                    end else begin
                        r_err   <= m_c;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (abs_err > $signed({5'd0, r_turn_thr})) begin
                        if (r_err > 0) begin
                            r_motor <= motor_set(duty_sat, 1'b0, 1'b1, 1'b0, 1'b1);
                            r_m     <= hd_ext + $signed({5'd0, r_turn_step});
                        end else begin
                            r_motor <= motor_set(duty_sat, 1'b1, 1'b0, 1'b1, 1'b0);
                            r_m     <= hd_ext - $signed({5'd0, r_turn_step});
                        end
                        r_state <= S_TURN_MOD;
                    end else begin
                        r_motor <= motor_set(duty_sat, 1'b0, 1'b1, 1'b1, 1'b0);
                        r_m     <= hd_ext + wfdr_pkg::DEG180;
                        r_state <= S_SC_WRAP;
                    end
                end
                S_TURN_MOD: begin
                    // truncating remainder, sign of the sum kept
                    priority if (r_m >= wfdr_pkg::DEG360) begin
                        r_m <= m_sub;
                    end else if (r_m <= -wfdr_pkg::DEG360) begin
                        r_m <= m_add;
                    end else begin
                        r_hd    <= r_m[25:0];
                        r_state <= S_FINISH;
                    end
                end
                S_SC_WRAP: begin
                    r_vec <= 1'b0;
                    r_i   <= '0;
                    priority if (r_m >= wfdr_pkg::DEG360) begin
                        r_m <= m_sub;
                    end else if (r_m < 0) begin
                        r_m <= m_add;
                    end else if (m_c > wfdr_pkg::DEG90) begin
                        r_a     <= '0;
                        r_b     <= wfdr_pkg::CORDIC_GAIN;
                        r_z     <= ZW'(m_c - wfdr_pkg::DEG90);
                        r_state <= S_CORD;
                    end else if (m_c < -wfdr_pkg::DEG90) begin
                        r_a     <= '0;
                        r_b     <= -wfdr_pkg::CORDIC_GAIN;
                        r_z     <= ZW'(m_c + wfdr_pkg::DEG90);
                        r_state <= S_CORD;
                    end else begin
                        r_a     <= wfdr_pkg::CORDIC_GAIN;
                        r_b     <= '0;
                        r_z     <= ZW'(m_c);
                        r_state <= S_CORD;
                    end
                end
                S_MUL_S: begin
                    r_prod  <= m_p;
                    r_state <= S_ADD_S;
                end
                S_ADD_S: begin
                    r_px    <= sat32(sum_x);
                    r_prod  <= m_p;
                    r_state <= S_ADD_C;
                end
                S_ADD_C: begin
                    r_py    <= sat32(sum_y);
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_motor   <= r_motor;
                        r_o_px      <= r_px;
                        r_o_py      <= r_py;
                        r_o_hd      <= r_hd;
                        r_o_lvl     <= r_fill;
                        r_o_drop    <= r_dropped;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_left_in1     = r_o_motor.l1;
    assign o_left_in2     = r_o_motor.l2;
    assign o_left_pwm     = r_o_motor.lpwm;
    assign o_right_in1    = r_o_motor.r1;
    assign o_right_in2    = r_o_motor.r2;
    assign o_right_pwm    = r_o_motor.rpwm;
    assign o_pose_x_out   = r_o_px;
    assign o_pose_y_out   = r_o_py;
    assign o_heading_out  = r_o_hd;
    assign o_queue_level  = 7'(r_o_lvl);
    assign o_push_dropped = r_o_drop;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(wfdr_pkg::QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input taken again before result");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_fill == $past(r_fill) + 1'b1)
        else $error("push did not raise fill");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECIDE |-> (r_err >= -wfdr_pkg::DEG180 && r_err < wfdr_pkg::DEG180))
        else $error("heading error out of range");

    a_halt_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_motor.l1 && r_motor.l2 && r_motor.r1 && r_motor.r2
                      && r_motor.lpwm == 10'd0 && r_motor.rpwm == 10'd0))
        else $error("motors driven while halted");
`endif

endmodule

`default_nettype wire
